// ===== rtl/wbf_pkg.sv =====
// ----------------------------------------------------------------------------
// wbf_pkg
// Shared types and constants for the weight bounded FIFO with head drop.
// ----------------------------------------------------------------------------
package wbf_pkg;

  localparam int ID_W        = 16;
  localparam int WEIGHT_W    = 16;
  localparam int LIMIT_W     = 20;
  localparam int TOTAL_OUT_W = 20;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 20;

  // at most this many auto-dispatch results per add
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [TOTAL_OUT_W-1:0] TOTAL_MAX   = '1;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_EN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = CFG_IDX_W'(1);

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_DEPART = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEPART = 2'd0,
    KIND_AUTO   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

endpackage

// ===== rtl/wbf_in_if.sv =====
// ----------------------------------------------------------------------------
// wbf_in_if
// Request channel: add or depart words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wbf_in_if import wbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ID_W-1:0]     entry_id;
  logic [WEIGHT_W-1:0] entry_weight;

  modport source (output valid, output mode, output entry_id, output entry_weight,
                  input ready);
  modport sink   (input valid, input mode, input entry_id, input entry_weight,
                  output ready);
endinterface

// ===== rtl/wbf_out_if.sv =====
// ----------------------------------------------------------------------------
// wbf_out_if
// Result channel: one word per removal, empty report or rejected add.
// ----------------------------------------------------------------------------
interface wbf_out_if import wbf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [ID_W-1:0]        out_id;
  logic [WEIGHT_W-1:0]    out_weight;
  logic [TOTAL_OUT_W-1:0] total_after;
  logic                   last;

  modport source (output valid, output kind, output out_id, output out_weight,
                  output total_after, output last, input ready);
  modport sink   (input valid, input kind, input out_id, input out_weight,
                  input total_after, input last, output ready);
endinterface

// ===== rtl/wbf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wbf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wbf_cfg_if import wbf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wbf_ram.sv =====
// ----------------------------------------------------------------------------
// wbf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wbf_front.sv =====
// ----------------------------------------------------------------------------
// wbf_front
// Accepts request words, decodes the operation and queues them for the back.
// ----------------------------------------------------------------------------
module wbf_front import wbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wbf_in_if.sink      in_if,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;
  cmd_t              in_cmd;

  assign in_if.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop         = cmd_valid && cmd_ready;

  assign in_cmd.op     = op_t'(in_if.mode);
  assign in_cmd.id     = in_if.entry_id;
  assign in_cmd.weight = in_if.entry_weight;

  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("command queue count out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCNT_W'(QDEPTH)) |-> !in_if.ready)
    else $error("request accepted into a full command queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop)
    else $error("command popped from an empty queue");
`endif

endmodule

// ===== rtl/wbf_back.sv =====
// ----------------------------------------------------------------------------
// wbf_back
// Executes queued commands on the slot ring and drives the result channel.
// ----------------------------------------------------------------------------
module wbf_back import wbf_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  input  logic               auto_en,
  input  logic [LIMIT_W-1:0] weight_limit,
  wbf_out_if.source          out_if
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TW_RAW  = WEIGHT_W + CNT_W;
  localparam int TOTAL_W = (TW_RAW > TOTAL_OUT_W + 1) ? TW_RAW : TOTAL_OUT_W + 1;
  localparam int SLOT_W  = ID_W + WEIGHT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_POP
  } state_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [NRES_W-1:0]    nres_r, nres_nxt;
  kind_t                pop_kind_r, pop_kind_nxt;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]        out_id_r, out_id_nxt;
  logic [WEIGHT_W-1:0]    out_weight_r, out_weight_nxt;
  logic [TOTAL_OUT_W-1:0] out_total_r, out_total_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                 ram_we, ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [SLOT_W-1:0]    ram_rdata;

  logic                   out_free;
  logic                   full;
  logic [TOTAL_W-1:0]     limit_ext;
  logic [ID_W-1:0]        rd_id;
  logic [WEIGHT_W-1:0]    rd_weight;
  logic [TOTAL_W-1:0]     total_pop;
  logic [CNT_W-1:0]       count_pop;
  logic [PTR_W-1:0]       head_pop;
  logic [TOTAL_OUT_W-1:0] total_sat;
  logic [TOTAL_OUT_W-1:0] total_pop_sat;
  logic                   more;

  wbf_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({cmd.id, cmd.weight}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_if.ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign limit_ext = TOTAL_W'(weight_limit);

  assign rd_id     = ram_rdata[SLOT_W-1:WEIGHT_W];
  assign rd_weight = ram_rdata[WEIGHT_W-1:0];
  assign total_pop = total_r - TOTAL_W'(rd_weight);
  assign count_pop = count_r - CNT_W'(1);
  assign head_pop  = ring_next(head_r);

  // report totals beyond the output range as saturated
  assign total_sat     = (total_r > TOTAL_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : total_r[TOTAL_OUT_W-1:0];
  assign total_pop_sat = (total_pop > TOTAL_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                            : total_pop[TOTAL_OUT_W-1:0];

  assign more = (pop_kind_r == KIND_AUTO) && auto_en && (total_pop > limit_ext) &&
                (count_pop != '0) && (nres_r < NRES_W'(MAX_RESULTS - 1));

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    nres_nxt       = nres_r;
    pop_kind_nxt   = pop_kind_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_weight_nxt = out_weight_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    cmd_ready      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          if (cmd.op == OP_DEPART) begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_EMPTY;
              out_id_nxt     = '0;
              out_weight_nxt = '0;
              out_total_nxt  = total_sat;
              out_last_nxt   = 1'b1;
            end else begin
              ram_re       = 1'b1;
              pop_kind_nxt = KIND_DEPART;
              state_nxt    = S_POP;
            end
          end else if (full) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_REJECT;
            out_id_nxt     = cmd.id;
            out_weight_nxt = cmd.weight;
            out_total_nxt  = total_sat;
            out_last_nxt   = 1'b1;
          end else begin
            ram_we    = 1'b1;
            tail_nxt  = ring_next(tail_r);
            count_nxt = count_r + CNT_W'(1);
            total_nxt = total_r + TOTAL_W'(cmd.weight);
            nres_nxt  = '0;
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        // the slot write has landed; start reading the head if over the limit
        if (auto_en && (total_r > limit_ext)) begin
          ram_re       = 1'b1;
          pop_kind_nxt = KIND_AUTO;
          state_nxt    = S_POP;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_POP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pop_kind_r;
          out_id_nxt     = rd_id;
          out_weight_nxt = rd_weight;
          out_total_nxt  = total_pop_sat;
          out_last_nxt   = !more;
          head_nxt       = head_pop;
          count_nxt      = count_pop;
          total_nxt      = total_pop;
          if (more) begin
            // fetch the next head while this word goes out
            ram_re    = 1'b1;
            ram_raddr = head_pop;
            nres_nxt  = nres_r + NRES_W'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      total_r     <= '0;
      nres_r      <= '0;
      pop_kind_r  <= KIND_DEPART;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      nres_r      <= nres_nxt;
      pop_kind_r  <= pop_kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_weight_r <= out_weight_nxt;
    out_total_r  <= out_total_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.out_id      = out_id_r;
  assign out_if.out_weight  = out_weight_r;
  assign out_if.total_after = out_total_r;
  assign out_if.last        = out_last_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds ring depth");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0))
    else $error("weight total nonzero with empty ring");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (count_r != '0))
    else $error("pop issued on empty ring");

  a_ring_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == '0) || (count_r == CNT_W'(DEPTH))) |-> (head_r == tail_r))
    else $error("head and tail disagree with entry count");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r < NRES_W'(MAX_RESULTS))
    else $error("auto-dispatch burst too long");
`endif

endmodule

// ===== rtl/weight_bounded_fifo_head_drop.sv =====
// ----------------------------------------------------------------------------
// weight_bounded_fifo_head_drop
// Weighted FIFO over a ring of slots that drops entries from the head while
// the stored weight exceeds a programmable limit.
// ----------------------------------------------------------------------------
// An empty or reject result is registered from the accepting cycle. A depart
// reads the head slot and registers its result from S_POP. An add writes its slot,
// then in S_CHECK reads the head if over the limit, then pops it in S_POP, where
// auto-dispatch results stream at one per cycle unless the output stalls. The
// back end takes a command only in S_IDLE. Slot writes land before head reads.
// Reset clears pointers, counts, total, config and output valid; slots, queue and output data are not cleared.
module weight_bounded_fifo_head_drop import wbf_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  wbf_in_if.sink     in_if,
  wbf_out_if.source  out_if,
  wbf_cfg_if.sink    cfg_if
);

  logic               auto_en_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_en_r <= 1'b0;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_AUTO_EN: auto_en_r <= cfg_if.data[0];
        CFG_LIMIT:   limit_r   <= cfg_if.data[LIMIT_W-1:0];
        default:     ;
      endcase
    end
  end

  wbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  wbf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .auto_en      (auto_en_r),
    .weight_limit (limit_r),
    .out_if       (out_if)
  );

endmodule
